// File: hdl/cc20ks_pkg.sv
// ----------------------------------------------------------------------------
// cc20ks_pkg
// Shared types, constants and round functions for the ChaCha20 keystream core.
// ----------------------------------------------------------------------------
package cc20ks_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] state_t;
	typedef word_t [7:0]  key_t;
	typedef word_t [2:0]  nonce_t;
	typedef word_t [3:0]  quad_t;

	// block / word indexes on the result channel
	localparam int IDX_W = 3;
	typedef logic [IDX_W-1:0] idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_01   = 3'd0,
		CFG_KEY_23   = 3'd1,
		CFG_KEY_45   = 3'd2,
		CFG_KEY_67   = 3'd3,
		CFG_NONCE_01 = 3'd4,
		CFG_NONCE_2  = 3'd5
	} cfg_idx_t;

	// "expand 32-byte k"
	localparam word_t SIGMA0 = 32'h6170_7865;
	localparam word_t SIGMA1 = 32'h3320_646e;
	localparam word_t SIGMA2 = 32'h7962_2d32;
	localparam word_t SIGMA3 = 32'h6b20_6574;

	function automatic state_t make_init(key_t key, nonce_t nonce, word_t ctr);
		state_t s;
		begin
			s[0] = SIGMA0;
			s[1] = SIGMA1;
			s[2] = SIGMA2;
			s[3] = SIGMA3;
			for (int i = 0; i < 8; i++) begin
				s[4+i] = key[i];
			end
			s[12] = ctr;
			s[13] = nonce[0];
			s[14] = nonce[1];
			s[15] = nonce[2];
			return s;
		end
	endfunction

	// q = {d, c, b, a}
	function automatic quad_t quarter(quad_t q);
		word_t a, b, c, d;
		begin
			a = q[0]; b = q[1]; c = q[2]; d = q[3];
			a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
			c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
			a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
			c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
			return {d, c, b, a};
		end
	endfunction

	// diag = 0: column round, diag = 1: diagonal round
	function automatic state_t half_round(state_t s, logic diag);
		state_t r;
		quad_t  q;
		logic [1:0] sh;
		logic [3:0] ib, ic, id;
		begin
			r = s;
			for (int i = 0; i < 4; i++) begin
				sh = diag ? 2'd1 : 2'd0;
				ib = {2'b01, 2'(i) + sh};
				ic = {2'b10, 2'(i) + sh + sh};
				id = {2'b11, 2'(i) + sh + sh + sh};
				q = quarter({s[id], s[ic], s[ib], s[i]});
				r[i]  = q[0];
				r[ib] = q[1];
				r[ic] = q[2];
				r[id] = q[3];
			end
			return r;
		end
	endfunction

endpackage

// File: hdl/chacha20_keystream_x8.sv
// ----------------------------------------------------------------------------
// chacha20_keystream_x8
// ChaCha20 block function, several consecutive counter blocks per input beat.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/block_counter): one beat starts a run of
//    BLOCKS_PER_ITEM blocks using counters block_counter + j (mod 2^32).
//  - Output channel: one 64-bit keystream word per beat, eight per block,
//    ordered by block then word; last_word flags word 7 of the last block.
//  - Config port (cfg_we/cfg_index/cfg_data): key and nonce; the user must
//    write them only while idle, which the block does not enforce; writes to
//    unknown indexes are dropped.
//  - First word: the block issues into stage 0, gets one round per pipeline
//    stage, then a final add into the output buffer before it is shown.
//  - Throughput: set by the output channel moving one word a cycle while
//    out_ready is high; the round pipeline takes a new block every cycle
//    unless an output stall freezes it, and holds up to 2*DOUBLE_ROUNDS+1 blocks.
//  - The next input beat is taken as the last block of the current one issues.
//  - Reset clears all valid bits and key/nonce registers.
//  - Output stall: the whole round pipeline freezes while its last stage holds
//    a block and the output buffer is full with its last word not taken;
//    nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module chacha20_keystream_x8 #(
	parameter int BLOCKS_PER_ITEM = 8,
	parameter int DOUBLE_ROUNDS   = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config
	input  logic                          cfg_we,
	input  logic [cc20ks_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cc20ks_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   block_counter,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [63:0]                   keystream_bits,
	output logic [2:0]                    block_number,
	output logic [2:0]                    word_pair,
	output logic                          last_word
);
	import cc20ks_pkg::*;

	localparam int   NSTG     = 2 * DOUBLE_ROUNDS;
	localparam idx_t LAST_BLK = IDX_W'(BLOCKS_PER_ITEM - 1);
	localparam idx_t LAST_WRD = IDX_W'(7);

	// ---------------- configuration ----------------
	key_t   key_q;
	nonce_t nonce_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			nonce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_01: begin
					key_q[0] <= cfg_data[31:0];
					key_q[1] <= cfg_data[63:32];
				end
				CFG_KEY_23: begin
					key_q[2] <= cfg_data[31:0];
					key_q[3] <= cfg_data[63:32];
				end
				CFG_KEY_45: begin
					key_q[4] <= cfg_data[31:0];
					key_q[5] <= cfg_data[63:32];
				end
				CFG_KEY_67: begin
					key_q[6] <= cfg_data[31:0];
					key_q[7] <= cfg_data[63:32];
				end
				CFG_NONCE_01: begin
					nonce_q[0] <= cfg_data[31:0];
					nonce_q[1] <= cfg_data[63:32];
				end
				CFG_NONCE_2: begin
					nonce_q[2] <= cfg_data[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic [NSTG:0] v_s;       // stage valid bits, bit k = after k rounds
	logic          adv;       // whole pipeline moves
	logic          load_ok;   // output buffer can take a block
	logic          inject;
	logic          last_inj;

	// block issuer
	logic  busy_q;
	word_t base_q;
	idx_t  jn_q;

	// output buffer
	state_t ks_q;
	idx_t   m_q;
	idx_t   ob_blk_q;
	logic   ov_q;

	assign load_ok  = !ov_q || (out_ready && (m_q == LAST_WRD));
	assign adv      = !v_s[NSTG] || load_ok;
	assign inject   = busy_q && adv;
	assign last_inj = (jn_q == LAST_BLK);
	assign in_ready = !busy_q || (adv && last_inj);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			jn_q   <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			jn_q   <= '0;
		end else if (inject) begin
			if (last_inj) begin
				busy_q <= 1'b0;
			end
			jn_q <= jn_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			base_q <= block_counter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NSTG-1:0], inject};
		end
	end

	// ---------------- round pipeline ----------------
	state_t x_s   [0:NSTG];
	word_t  ctr_s [0:NSTG];
	idx_t   blk_s [0:NSTG];

	// stage 0: initial state of the block being issued
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]   <= make_init(key_q, nonce_q, base_q + 32'(jn_q));
			ctr_s[0] <= base_q + 32'(jn_q);
			blk_s[0] <= jn_q;
		end
	end

	// stage k+1: one round on stage k, column on even k, diagonal on odd
	for (genvar k = 0; k < NSTG; k++) begin : g_round
		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[k+1]   <= half_round(x_s[k], ((k % 2) == 1));
				ctr_s[k+1] <= ctr_s[k];
				blk_s[k+1] <= blk_s[k];
			end
		end
	end

	// ---------------- final add and word serializer ----------------
	state_t init_fin;
	state_t sum_fin;

	always_comb begin
		init_fin = make_init(key_q, nonce_q, ctr_s[NSTG]);
		for (int i = 0; i < 16; i++) begin
			sum_fin[i] = x_s[NSTG][i] + init_fin[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			m_q  <= '0;
		end else if (v_s[NSTG] && load_ok) begin
			ov_q <= 1'b1;
			m_q  <= '0;
		end else if (ov_q && out_ready) begin
			if (m_q == LAST_WRD) begin
				ov_q <= 1'b0;
			end
			m_q <= m_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s[NSTG] && load_ok) begin
			ks_q     <= sum_fin;
			ob_blk_q <= blk_s[NSTG];
		end
	end

	assign out_valid      = ov_q;
	assign keystream_bits = {ks_q[{m_q, 1'b1}], ks_q[{m_q, 1'b0}]};
	assign block_number   = ob_blk_q;
	assign word_pair      = m_q;
	assign last_word      = (ob_blk_q == LAST_BLK) && (m_q == LAST_WRD);

	// ---------------- assertions ----------------
	a_jn_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (jn_q <= LAST_BLK))
		else $error("block issue index beyond last block");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[NSTG] && load_ok) |=> (ov_q && (m_q == '0)))
		else $error("output buffer load did not restart at word 0");

	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_ready && (m_q != LAST_WRD)) |=>
			(ov_q && (m_q == $past(m_q) + IDX_W'(1))))
		else $error("word sequence broken inside a block");

	a_no_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && !(in_valid && in_ready) && adv) |=> !v_s[0])
		else $error("block issued with no active input beat");

endmodule
